[src/mfp_pkg.sv]
// Shared types and constants for the marker framed two field parser.
// No dependencies; used by mfp_parser and the top level.
package mfp_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_START_MARKER = 2'd0;
    localparam logic [1:0] CFG_END_MARKER   = 2'd1;
    localparam logic [1:0] CFG_SEPARATOR    = 2'd2;

    // register reset values: '<', '>', ','
    localparam logic [7:0] START_MARKER_RST = 8'd60;
    localparam logic [7:0] END_MARKER_RST   = 8'd62;
    localparam logic [7:0] SEPARATOR_RST    = 8'd44;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // magnitude caps
    localparam logic [16:0] FIRST_CAP    = 17'd32768;
    localparam logic [16:0] FIRST_MAX    = 17'd32767;
    localparam logic [23:0] SECOND_CAP   = 24'd8388608;
    localparam logic [23:0] SECOND_MAX   = 24'd8388607;
    localparam logic [1:0]  FRAC_DIGITS  = 2'd2;

    typedef enum logic [1:0] {
        FP_BEFORE_FIRST = 2'd0,
        FP_IN_FIRST     = 2'd1,
        FP_BETWEEN      = 2'd2,
        FP_IN_SECOND    = 2'd3
    } field_pos_t;

    typedef enum logic [2:0] {
        NP_LEADING = 3'd0,
        NP_SIGNED  = 3'd1,
        NP_INT     = 3'd2,
        NP_FRAC    = 3'd3,
        NP_DONE    = 3'd4
    } num_phase_t;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] separator;
    } mfp_cfg_t;

    typedef struct packed {
        logic signed [15:0] mode_value;
        logic signed [23:0] target_hundredths;
        logic               first_missing;
        logic               second_missing;
    } mfp_result_t;

endpackage

[src/marker_framed_two_field_parser.sv]
// Top level of the marker framed two field parser: config registers,
// input beat register, output beat register. Depends on mfp_pkg, mfp_parser.
//
//   channel   direction  handshake             payload
//   in        sink       in_valid / in_stall   rx_byte
//   out       source     out_valid / out_stall mode_value, target_hundredths,
//                                              first_missing, second_missing
//   cfg       sink       cfg_we                cfg_index, cfg_data
//
// One byte per cycle sustained while no closing byte waits on a stalled
// output. A byte is parsed during the cycle it spends in the input register,
// and a closing byte's result is in the output register from the next cycle.
// Reset (rst_n, asynchronous) restores the markers to '<', '>', ','
// and leaves the block idle outside a frame. A stalled output only holds up
// a closing byte; other bytes keep flowing, and one byte is taken into the
// input register while a result waits.
module marker_framed_two_field_parser #(
    parameter int FRAME_CHARS = 32
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,

    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] mode_value,
    output logic signed [23:0] target_hundredths,
    output logic               first_missing,
    output logic               second_missing,

    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    // configuration registers
    logic [7:0] start_marker_reg;
    logic [7:0] end_marker_reg;
    logic [7:0] separator_reg;
    mfp_pkg::mfp_cfg_t cfg;

    // input beat register
    logic       byte_valid_reg, byte_valid_next;
    logic [7:0] byte_reg;

    // output beat register
    logic                 out_valid_reg, out_valid_next;
    mfp_pkg::mfp_result_t result_reg;
    mfp_pkg::mfp_result_t result;

    logic is_end;
    logic out_free;
    logic proc_fire;
    logic in_take;
    logic out_load;

    assign cfg.start_marker = start_marker_reg;
    assign cfg.end_marker   = end_marker_reg;
    assign cfg.separator    = separator_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= mfp_pkg::START_MARKER_RST;
            end_marker_reg   <= mfp_pkg::END_MARKER_RST;
            separator_reg    <= mfp_pkg::SEPARATOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mfp_pkg::CFG_START_MARKER: start_marker_reg <= cfg_data;
                mfp_pkg::CFG_END_MARKER:   end_marker_reg   <= cfg_data;
                mfp_pkg::CFG_SEPARATOR:    separator_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // a closing byte needs room in the output register; others never wait
    assign out_free  = !out_valid_reg || !out_stall;
    assign proc_fire = byte_valid_reg && (!is_end || out_free);
    assign out_load  = proc_fire && is_end;
    assign in_stall  = byte_valid_reg && !proc_fire;
    assign in_take   = in_valid && !in_stall;

    assign byte_valid_next = in_take || (byte_valid_reg && !proc_fire);
    assign out_valid_next  = out_load || (out_valid_reg && out_stall);

    mfp_parser #(
        .FRAME_CHARS (FRAME_CHARS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .byte_in (byte_reg),
        .fire    (proc_fire),
        .is_end  (is_end),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
            byte_reg <= rx_byte;
        if (out_load)
            result_reg <= result;
    end

    assign out_valid         = out_valid_reg;
    assign mode_value        = result_reg.mode_value;
    assign target_hundredths = result_reg.target_hundredths;
    assign first_missing     = result_reg.first_missing;
    assign second_missing    = result_reg.second_missing;

    // a result is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !out_load)
        else $error("result overwritten while stalled");

    // the input register only backs up on a closing byte
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> is_end && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");

    // a held byte is still there in the next cycle
    a_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> byte_valid_reg && $stable(byte_reg))
        else $error("held byte lost");

endmodule

[src/mfp_parser.sv]
// Frame tracking and on-the-fly number parsing, one byte per fire.
// Depends on mfp_pkg.
module mfp_parser #(
    parameter int FRAME_CHARS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mfp_pkg::mfp_cfg_t  cfg,
    input  logic [7:0]         byte_in,
    input  logic               fire,
    output logic               is_end,
    output mfp_pkg::mfp_result_t result
);

    localparam int KW = (FRAME_CHARS > 2) ? $clog2(FRAME_CHARS) : 1;
    localparam logic [KW-1:0] KEPT_MAX = KW'(FRAME_CHARS - 1);

    logic                  in_frame_reg, in_frame_next;
    logic [KW-1:0]         kept_reg, kept_next;
    mfp_pkg::field_pos_t   fp_reg, fp_next;
    mfp_pkg::num_phase_t   phase_reg, phase_next;
    logic                  neg_reg, neg_next;
    logic [16:0]           first_acc_reg, first_acc_next;
    logic [23:0]           second_acc_reg, second_acc_next;
    logic [1:0]            fd_reg, fd_next;

    logic                  is_digit, is_ws, is_sep, is_sign;
    logic [3:0]            digit;
    logic                  starting, in_second;
    mfp_pkg::num_phase_t   eff_phase;
    logic                  eff_neg;
    logic [1:0]            eff_fd;
    logic [19:0]           first_x10;
    logic [16:0]           first_dig;
    logic [27:0]           second_x10;
    logic [23:0]           second_dig;
    logic [16:0]           first_final;
    logic                  num_go, int_go, acc_go;

    logic [30:0]           sec_scaled;
    logic [23:0]           sec_sat;
    logic [23:0]           second_final;

    // byte classes
    assign is_digit  = (byte_in >= mfp_pkg::CH_ZERO) && (byte_in <= mfp_pkg::CH_NINE);
    assign digit     = byte_in[3:0];
    assign is_ws     = (byte_in == mfp_pkg::CH_SPACE)
                    || ((byte_in >= mfp_pkg::CH_TAB) && (byte_in <= mfp_pkg::CH_CR));
    assign is_sign   = (byte_in == mfp_pkg::CH_PLUS) || (byte_in == mfp_pkg::CH_MINUS);
    assign is_sep    = (byte_in == cfg.separator);
    assign is_end    = in_frame_reg && (byte_in == cfg.end_marker);

    // a token starts at the first non-separator byte in either gap
    assign starting  = (fp_reg == mfp_pkg::FP_BEFORE_FIRST) || (fp_reg == mfp_pkg::FP_BETWEEN);
    assign in_second = fp_reg[1];
    assign eff_phase = starting ? mfp_pkg::NP_LEADING : phase_reg;
    assign eff_neg   = starting ? 1'b0 : neg_reg;
    assign eff_fd    = starting ? 2'd0 : fd_reg;

    // acc*10 + digit, saturating
    assign first_x10  = 20'({first_acc_reg, 3'b000}) + 20'({first_acc_reg, 1'b0}) + 20'(digit);
    assign first_dig  = (first_x10 > 20'(mfp_pkg::FIRST_CAP)) ? mfp_pkg::FIRST_CAP
                                                               : first_x10[16:0];
    assign second_x10 = 28'({second_acc_reg, 3'b000}) + 28'({second_acc_reg, 1'b0})
                      + 28'(digit);
    assign second_dig = (second_x10 > 28'(mfp_pkg::SECOND_CAP)) ? mfp_pkg::SECOND_CAP
                                                                 : second_x10[23:0];

    // first token made final: negative wraps in 17 bits, positive clamps
    assign first_final = neg_reg ? (17'd0 - first_acc_reg)
                       : ((first_acc_reg > mfp_pkg::FIRST_MAX) ? mfp_pkg::FIRST_MAX
                                                                : first_acc_reg);

    // second token scaled to hundredths for missing fraction digits
    always_comb
    begin
        case (fd_reg)
            2'd0:    sec_scaled = 31'({second_acc_reg, 6'b0}) + 31'({second_acc_reg, 5'b0})
                                + 31'({second_acc_reg, 2'b0});
            2'd1:    sec_scaled = 31'({second_acc_reg, 3'b0}) + 31'({second_acc_reg, 1'b0});
            default: sec_scaled = 31'(second_acc_reg);
        endcase
    end

    assign sec_sat      = (sec_scaled > 31'(mfp_pkg::SECOND_CAP)) ? mfp_pkg::SECOND_CAP
                                                                   : sec_scaled[23:0];
    assign second_final = neg_reg ? (24'd0 - sec_sat)
                        : ((sec_sat > mfp_pkg::SECOND_MAX) ? mfp_pkg::SECOND_MAX : sec_sat);

    // next state
    always_comb
    begin : next_state
        in_frame_next   = in_frame_reg;
        kept_next       = kept_reg;
        fp_next         = fp_reg;
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        first_acc_next  = first_acc_reg;
        second_acc_next = second_acc_reg;
        fd_next         = fd_reg;
        num_go          = 1'b0;
        int_go          = 1'b0;
        acc_go          = 1'b0;

        if (fire)
        begin
            if ((!in_frame_reg && (byte_in == cfg.start_marker)) || is_end)
            begin
                in_frame_next   = !in_frame_reg;
                kept_next       = '0;
                fp_next         = mfp_pkg::FP_BEFORE_FIRST;
                phase_next      = mfp_pkg::NP_LEADING;
                neg_next        = 1'b0;
                first_acc_next  = '0;
                second_acc_next = '0;
                fd_next         = '0;
            end
            else if (in_frame_reg && (kept_reg < KEPT_MAX))
            begin
                kept_next = kept_reg + KW'(1);
                unique case (fp_reg)
                    mfp_pkg::FP_BEFORE_FIRST:
                    begin
                        if (!is_sep)
                        begin
                            fp_next = mfp_pkg::FP_IN_FIRST;
                            num_go  = 1'b1;
                        end
                    end
                    mfp_pkg::FP_IN_FIRST:
                    begin
                        if (is_sep)
                        begin
                            first_acc_next = first_final;
                            neg_next       = 1'b0;
                            fp_next        = mfp_pkg::FP_BETWEEN;
                        end
                        else
                            num_go = 1'b1;
                    end
                    mfp_pkg::FP_BETWEEN:
                    begin
                        if (!is_sep)
                        begin
                            fp_next = mfp_pkg::FP_IN_SECOND;
                            num_go  = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (is_sep)
                            phase_next = mfp_pkg::NP_DONE;
                        else
                            num_go = 1'b1;
                    end
                endcase
            end
        end

        // number syntax step
        if (num_go)
        begin
            phase_next = eff_phase;
            neg_next   = eff_neg;
            fd_next    = eff_fd;
            case (eff_phase)
                mfp_pkg::NP_LEADING:
                begin
                    if (is_sign)
                    begin
                        neg_next   = (byte_in == mfp_pkg::CH_MINUS);
                        phase_next = mfp_pkg::NP_SIGNED;
                    end
                    else if (!is_ws)
                        int_go = 1'b1;
                end
                mfp_pkg::NP_SIGNED, mfp_pkg::NP_INT:
                    int_go = 1'b1;
                mfp_pkg::NP_FRAC:
                begin
                    if (is_digit)
                    begin
                        if (eff_fd < mfp_pkg::FRAC_DIGITS)
                        begin
                            acc_go  = 1'b1;
                            fd_next = eff_fd + 2'd1;
                        end
                    end
                    else
                        phase_next = mfp_pkg::NP_DONE;
                end
                default: ;
            endcase

            if (int_go)
            begin
                if (is_digit)
                begin
                    acc_go     = 1'b1;
                    phase_next = mfp_pkg::NP_INT;
                end
                else if (in_second && (byte_in == mfp_pkg::CH_DOT))
                    phase_next = mfp_pkg::NP_FRAC;
                else
                    phase_next = mfp_pkg::NP_DONE;
            end

            if (acc_go)
            begin
                if (in_second)
                    second_acc_next = second_dig;
                else
                    first_acc_next = first_dig;
            end
        end
    end

    // result of a closing byte
    always_comb
    begin : result_out
        result.mode_value        = '0;
        result.target_hundredths = '0;
        result.first_missing     = 1'b1;
        result.second_missing    = 1'b1;
        unique case (fp_reg)
            mfp_pkg::FP_IN_FIRST:
            begin
                result.mode_value    = first_final[15:0];
                result.first_missing = 1'b0;
            end
            mfp_pkg::FP_BETWEEN:
            begin
                result.mode_value    = first_acc_reg[15:0];
                result.first_missing = 1'b0;
            end
            mfp_pkg::FP_IN_SECOND:
            begin
                result.mode_value        = first_acc_reg[15:0];
                result.first_missing     = 1'b0;
                result.target_hundredths = second_final;
                result.second_missing    = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            kept_reg       <= '0;
            fp_reg         <= mfp_pkg::FP_BEFORE_FIRST;
            phase_reg      <= mfp_pkg::NP_LEADING;
            neg_reg        <= 1'b0;
            first_acc_reg  <= '0;
            second_acc_reg <= '0;
            fd_reg         <= '0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            kept_reg       <= kept_next;
            fp_reg         <= fp_next;
            phase_reg      <= phase_next;
            neg_reg        <= neg_next;
            first_acc_reg  <= first_acc_next;
            second_acc_reg <= second_acc_next;
            fd_reg         <= fd_next;
        end
    end

    // closing byte always leaves the block idle
    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_end |=> !in_frame_reg && (kept_reg == '0))
        else $error("frame not closed after end marker");

    // nothing is counted outside a frame
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (kept_reg == '0) && (fp_reg == mfp_pkg::FP_BEFORE_FIRST))
        else $error("parse state live while idle");

    // fraction digits are capped at two
    a_fd_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fd_reg != 2'd3)
        else $error("fraction digit count overflow");

    // second magnitude saturates at its cap
    a_second_cap: assert property (@(posedge clk) disable iff (!rst_n)
        second_acc_reg <= mfp_pkg::SECOND_CAP)
        else $error("second accumulator beyond cap");

endmodule
